[design/wre_pkg.sv]
// Package for the weighted rotor estimator: constants, types and helper functions.
package wre_pkg;

  localparam int FracBitsDef = 16;
  localparam int NumSums     = 9;
  localparam int NormBits    = 20;
  localparam int NumTerms    = 24;
  localparam int CnW         = NormBits + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_CSUM,
    S_NORM,
    S_POLY,
    S_DIV,
    S_DWAIT,
    S_OUT
  } wre_state_e;

  // One triple product of the closed-form solve: sign * c[ia] * c[ib] * c[ic].
  typedef struct packed {
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic       neg;
    logic [1:0] tgt;   // 0: determinant, 1..3: numerators x, y, z
  } wre_term_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } wre_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } wre_div_rsp_t;

  function automatic wre_term_t term_lookup(input logic [4:0] k);
    wre_term_t t;
    unique case (k)
      5'd0:  t = '{4'd0, 4'd6, 4'd6, 1'b0, 2'd0};
      5'd1:  t = '{4'd1, 4'd7, 4'd7, 1'b0, 2'd0};
      5'd2:  t = '{4'd2, 4'd8, 4'd8, 1'b0, 2'd0};
      5'd3:  t = '{4'd6, 4'd7, 4'd8, 1'b0, 2'd0};
      5'd4:  t = '{4'd6, 4'd7, 4'd8, 1'b0, 2'd0};
      5'd5:  t = '{4'd0, 4'd1, 4'd2, 1'b1, 2'd0};
      5'd6:  t = '{4'd0, 4'd2, 4'd3, 1'b1, 2'd1};
      5'd7:  t = '{4'd7, 4'd7, 4'd3, 1'b0, 2'd1};
      5'd8:  t = '{4'd0, 4'd6, 4'd4, 1'b1, 2'd1};
      5'd9:  t = '{4'd7, 4'd8, 4'd4, 1'b1, 2'd1};
      5'd10: t = '{4'd2, 4'd8, 4'd5, 1'b1, 2'd1};
      5'd11: t = '{4'd6, 4'd7, 4'd5, 1'b1, 2'd1};
      5'd12: t = '{4'd1, 4'd0, 4'd4, 1'b1, 2'd2};
      5'd13: t = '{4'd8, 4'd8, 4'd4, 1'b0, 2'd2};
      5'd14: t = '{4'd1, 4'd7, 4'd5, 1'b1, 2'd2};
      5'd15: t = '{4'd8, 4'd6, 4'd5, 1'b1, 2'd2};
      5'd16: t = '{4'd0, 4'd6, 4'd3, 1'b1, 2'd2};
      5'd17: t = '{4'd7, 4'd8, 4'd3, 1'b1, 2'd2};
      5'd18: t = '{4'd2, 4'd1, 4'd5, 1'b1, 2'd3};
      5'd19: t = '{4'd6, 4'd6, 4'd5, 1'b0, 2'd3};
      5'd20: t = '{4'd2, 4'd8, 4'd3, 1'b1, 2'd3};
      5'd21: t = '{4'd6, 4'd7, 4'd3, 1'b1, 2'd3};
      5'd22: t = '{4'd1, 4'd7, 4'd4, 1'b1, 2'd3};
      5'd23: t = '{4'd8, 4'd6, 4'd4, 1'b1, 2'd3};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  // floor((a+b)/2) without overflow
  function automatic logic signed [63:0] half_sum64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return s[64:1];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

[design/wre_if.sv]
// Item channels of the weighted rotor estimator: atom input and rotor result.
interface wre_atom_if;
  logic               valid;
  logic               ready;
  logic        [15:0] weight;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] bond_x;
  logic signed [31:0] bond_y;
  logic signed [31:0] bond_z;
  logic               last_atom;

  modport source (output valid, weight, pos_x, pos_y, pos_z, bond_x, bond_y, bond_z,
                  last_atom, input ready);
  modport sink   (input valid, weight, pos_x, pos_y, pos_z, bond_x, bond_y, bond_z,
                  last_atom, output ready);
endinterface

interface wre_rotor_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotor_x;
  logic signed [31:0] rotor_y;
  logic signed [31:0] rotor_z;
  logic               singular;

  modport source (output valid, rotor_x, rotor_y, rotor_z, singular, input ready);
  modport sink   (input valid, rotor_x, rotor_y, rotor_z, singular, output ready);
endinterface

[design/wre_div.sv]
// Bit-serial fixed-point divider: saturating N * 2^FracBits / D into signed 32 bits.
module wre_div #(
  parameter int FracBits = wre_pkg::FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wre_pkg::wre_div_req_t req_i,
  output wre_pkg::wre_div_rsp_t rsp_o
);
  import wre_pkg::*;

  localparam int IntBits = 32 - FracBits;

  logic        busy_q, done_q, sat_q, neg_q;
  logic [63:0] ud_q, r_q;
  logic [31:0] nsh_q, quo_q;
  logic [4:0]  cnt_q;

  logic [63:0] un, ud;
  logic        sat_chk;
  logic [64:0] rs, rdiff;
  logic        ge;
  logic [31:0] qu, qm;

  always_comb begin
    un      = mag64(req_i.num);
    ud      = mag64(req_i.den);
    sat_chk = {32'b0, un} >= ({32'b0, ud} << IntBits);
    rs      = {r_q, nsh_q[31]};
    ge      = rs >= {1'b0, ud_q};
    rdiff   = rs - {1'b0, ud_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        if (sat_chk) begin
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[63] ^ req_i.den[63];
      sat_q <= sat_chk;
      ud_q  <= ud;
      r_q   <= un >> IntBits;
      nsh_q <= 32'(un << FracBits);
      quo_q <= '0;
    end else if (busy_q) begin
      r_q   <= ge ? rdiff[63:0] : rs[63:0];
      quo_q <= {quo_q[30:0], ge};
      nsh_q <= {nsh_q[30:0], 1'b0};
    end
  end

  always_comb begin
    qu = sat_q ? 32'hFFFF_FFFF : quo_q;
    if (neg_q) begin
      qm = (qu > 32'h8000_0000) ? 32'h8000_0000 : qu;
      rsp_o.quo = -$signed(qm);
    end else begin
      qm = (qu > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qu;
      rsp_o.quo = $signed(qm);
    end
    rsp_o.done = done_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (busy_q && cnt_q == 5'd31) |=> done_q)
    else $error("divider did not finish after 32 steps");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q && !req_i.start |=> !sat_q)
    else $error("saturated quotient went through the bit loop");

endmodule

[design/weighted_rotor_estimator_unit.sv]
// Weighted rotor estimator top level: accumulate w*p_i*b_j, then solve for the rotor.
// An atom takes 9 products of 3 multiplies each on the one shared 33x33 multiplier,
// after the cycle in which it is accepted; not ready meanwhile.
// A last atom then adds the sum step, normalization, the solve (24 triple products x 3
// multiplies), then 3 divisions, or none if the determinant is zero.
// The result waits in an output register until taken; then the next atom is accepted.
// Reset (async, active low): idle, accumulators zero, no result pending.
module weighted_rotor_estimator_unit #(
  parameter int FracBits = wre_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wre_atom_if.sink    atom_i,
  wre_rotor_if.source rotor_o
);
  import wre_pkg::*;

  wre_state_e state_q, state_d;

  // latched atom
  logic        [15:0] w_q;
  logic signed [31:0] p_q [3];
  logic signed [31:0] b_q [3];
  logic               last_q;

  // sequencing counters: ph = multiply / consume, sub = multiply within a step
  logic       ph_q;
  logic [1:0] sub_q;
  logic [3:0] j_q;
  logic [1:0] pi_q, bi_q;
  logic [4:0] k_q;
  logic [1:0] tg_q;
  logic       step_last;

  // shared multiplier and its operand registers
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_q;
  logic signed [63:0] q_q;
  logic        [63:0] lo_q;
  logic signed [41:0] t_q;

  logic signed [63:0] acc_q [NumSums];
  logic        [63:0] mag_q [NumSums];
  logic               neg_q [NumSums];
  logic signed [CnW-1:0] cn [NumSums];
  logic signed [63:0] nd_q [4];

  logic signed [31:0] rot_q [3];
  logic               sing_q;

  logic               big;
  logic signed [79:0] full;
  logic signed [63:0] term;
  logic signed [63:0] cv [NumSums];
  wre_term_t          tm;
  logic signed [63:0] pv;

  wre_div_req_t div_req;
  wre_div_rsp_t div_rsp;

  assign step_last = ph_q && (sub_q == 2'd2);
  assign tm        = term_lookup(k_q);

  // normalized solve inputs: sign * (|C| >> s), fits in NormBits+1 bits
  always_comb begin
    for (int i = 0; i < NumSums; i++) begin
      cn[i] = neg_q[i] ? -$signed({1'b0, mag_q[i][NormBits-1:0]})
                       : $signed({1'b0, mag_q[i][NormBits-1:0]});
    end
  end

  // C1..C9 from the accumulators
  always_comb begin
    cv[0] = sat_add64(acc_q[0], acc_q[4]);
    cv[1] = sat_add64(acc_q[4], acc_q[8]);
    cv[2] = sat_add64(acc_q[8], acc_q[0]);
    cv[3] = sat_sub64(acc_q[7], acc_q[5]);
    cv[4] = sat_sub64(acc_q[2], acc_q[6]);
    cv[5] = sat_sub64(acc_q[3], acc_q[1]);
    cv[6] = half_sum64(acc_q[1], acc_q[3]);
    cv[7] = half_sum64(acc_q[5], acc_q[7]);
    cv[8] = half_sum64(acc_q[6], acc_q[2]);
  end

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < NumSums; i++) big = big | (|mag_q[i][63:NormBits]);
  end

  // term = floor(q*w/256) from the two partial products q_hi*w and q_lo*w
  always_comb begin
    full = (80'(prod_q) <<< 32) + $signed(80'(lo_q));
    term = full[71:8];
  end

  always_comb begin
    pv = tm.neg ? -prod_q[63:0] : prod_q[63:0];
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_ACC) begin
      case (sub_q)
        2'd0: begin
          ma = 33'(p_q[pi_q]);
          mb = 33'(b_q[bi_q]);
        end
        2'd1: begin
          ma = $signed({1'b0, q_q[31:0]});
          mb = $signed({17'b0, w_q});
        end
        default: begin
          ma = $signed({q_q[63], q_q[63:32]});
          mb = $signed({17'b0, w_q});
        end
      endcase
    end else begin
      case (sub_q)
        2'd0: begin
          ma = 33'(cn[tm.ia]);
          mb = 33'(cn[tm.ib]);
        end
        2'd1: begin
          ma = $signed({12'b0, t_q[20:0]});
          mb = 33'(cn[tm.ic]);
        end
        default: begin
          // upper half of the pair product carries the sign
          ma = 33'($signed(t_q[41:21]));
          mb = 33'(cn[tm.ic]);
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (atom_i.valid) state_d = S_ACC;
      S_ACC:   if (step_last && j_q == 4'd8) state_d = last_q ? S_CSUM : S_IDLE;
      S_CSUM:  state_d = S_NORM;
      S_NORM:  if (!big) state_d = S_POLY;
      S_POLY:  if (step_last && k_q == 5'(NumTerms - 1)) state_d = S_DIV;
      S_DIV:   state_d = (nd_q[0] == 64'sd0) ? S_OUT : S_DWAIT;
      S_DWAIT: if (div_rsp.done) state_d = (tg_q == 2'd2) ? S_OUT : S_DIV;
      S_OUT:   if (rotor_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // handshake and divider control
  always_comb begin
    atom_i.ready  = (state_q == S_IDLE);
    rotor_o.valid = (state_q == S_OUT);
    div_req.start = (state_q == S_DIV) && (nd_q[0] != 64'sd0);
    div_req.num   = nd_q[2'(tg_q + 2'd1)];
    div_req.den   = nd_q[0];
  end

  assign rotor_o.rotor_x  = rot_q[0];
  assign rotor_o.rotor_y  = rot_q[1];
  assign rotor_o.rotor_z  = rot_q[2];
  assign rotor_o.singular = sing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 1'b0;
      sub_q   <= '0;
      j_q     <= '0;
      pi_q    <= '0;
      bi_q    <= '0;
      k_q     <= '0;
      tg_q    <= '0;
      for (int i = 0; i < NumSums; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          ph_q  <= 1'b0;
          sub_q <= '0;
          j_q   <= '0;
          pi_q  <= '0;
          bi_q  <= '0;
        end
        S_ACC: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (sub_q == 2'd2) begin
              acc_q[j_q] <= sat_add64(acc_q[j_q], term);
              sub_q <= '0;
              j_q   <= j_q + 4'd1;
              if (bi_q == 2'd2) begin
                bi_q <= '0;
                pi_q <= pi_q + 2'd1;
              end else begin
                bi_q <= bi_q + 2'd1;
              end
            end else begin
              sub_q <= sub_q + 2'd1;
            end
          end
        end
        S_CSUM: begin
          // sums captured below; accumulators start the next group empty
          for (int i = 0; i < NumSums; i++) acc_q[i] <= '0;
          ph_q  <= 1'b0;
          sub_q <= '0;
          k_q   <= '0;
          tg_q  <= '0;
        end
        S_POLY: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (sub_q == 2'd2) begin
              sub_q <= '0;
              k_q   <= k_q + 5'd1;
            end else begin
              sub_q <= sub_q + 2'd1;
            end
          end
        end
        S_DWAIT: if (div_rsp.done) tg_q <= tg_q + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && atom_i.valid) begin
      w_q    <= atom_i.weight;
      p_q[0] <= atom_i.pos_x;
      p_q[1] <= atom_i.pos_y;
      p_q[2] <= atom_i.pos_z;
      b_q[0] <= atom_i.bond_x;
      b_q[1] <= atom_i.bond_y;
      b_q[2] <= atom_i.bond_z;
      last_q <= atom_i.last_atom;
    end
    if ((state_q == S_ACC || state_q == S_POLY) && !ph_q) prod_q <= ma * mb;
    if (state_q == S_ACC && ph_q) begin
      if (sub_q == 2'd0) q_q  <= $signed(prod_q[63:0]) >>> FracBits;
      if (sub_q == 2'd1) lo_q <= prod_q[63:0];
    end
    if (state_q == S_CSUM) begin
      for (int i = 0; i < NumSums; i++) begin
        mag_q[i] <= mag64(cv[i]);
        neg_q[i] <= cv[i][63];
      end
      for (int i = 0; i < 4; i++) nd_q[i] <= '0;
    end
    if (state_q == S_NORM && big) begin
      for (int i = 0; i < NumSums; i++) mag_q[i] <= mag_q[i] >> 1;
    end
    if (state_q == S_POLY && ph_q) begin
      case (sub_q)
        2'd0: t_q <= prod_q[41:0];
        2'd1: nd_q[tm.tgt] <= nd_q[tm.tgt] + pv;
        default: nd_q[tm.tgt] <= nd_q[tm.tgt] + (pv <<< 21);
      endcase
    end
    if (state_q == S_DIV) begin
      if (nd_q[0] == 64'sd0) begin
        for (int i = 0; i < 3; i++) rot_q[i] <= '0;
        sing_q <= 1'b1;
      end else begin
        sing_q <= 1'b0;
      end
    end
    if (state_q == S_DWAIT && div_rsp.done) rot_q[tg_q] <= div_rsp.quo;
  end

  wre_div #(
    .FracBits(FracBits)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) atom_i.ready |-> !rotor_o.valid)
    else $error("input ready while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rotor_o.valid && rotor_o.singular |->
                   rotor_o.rotor_x == 0 && rotor_o.rotor_y == 0 && rotor_o.rotor_z == 0)
    else $error("singular result with nonzero rotor");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_CSUM |=> acc_q[0] == 0 && acc_q[4] == 0 && acc_q[8] == 0)
    else $error("accumulators not cleared after solve");
  assert property (@(posedge clk_i) disable iff (!rst_ni) sub_q != 2'd3)
    else $error("multiply step counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_rsp.done |-> state_q == S_DWAIT)
    else $error("division finished outside its wait state");

endmodule

[verif/wre_tb_if.sv]
// Testbench note: the design interfaces are reused from design/wre_if.sv; this file holds none.
`timescale 1ns / 100ps
package wre_tb_types;
  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic               sing;
  } rotor_t;
endpackage

[verif/testbench.sv]
// Testbench for the weighted rotor estimator: directed and random atom groups against a built-in predictor.
`timescale 1ns / 100ps
module testbench;
  import wre_tb_types::*;

  localparam int FB = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fails = 0;
  longint cycles = 0;

  always #6 clk_i = ~clk_i;

  wre_atom_if  atom_ch ();
  wre_rotor_if rotor_ch ();

  weighted_rotor_estimator_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .atom_i (atom_ch.sink),
    .rotor_o(rotor_ch.source)
  );

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("MISMATCH %s: got %0d expected %0d", what, got, exp);
    fails++;
  endtask

  // Rotor predictor: keeps its own weighted product sums.
  class rotor_scoreboard;
    longint sums[9];
    rotor_t pending[$];

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'sh8000000000000000
                                                         : 64'sh7fffffffffffffff;
      return s;
    endfunction

    function longint sat_sub(longint a, longint b);
      longint s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? 64'sh8000000000000000
                                                         : 64'sh7fffffffffffffff;
      return s;
    endfunction

    function longint weighted_term(logic [15:0] w, longint p, longint b);
      longint q;
      logic signed [80:0] t;
      q = (p * b) >>> FB;
      t = 81'(q) * $signed({1'b0, w});
      return longint'(t >>> 8);
    endfunction

    function logic signed [31:0] rotor_quot(longint n, longint d);
      logic [63:0] un, ud, q, r;
      bit neg;
      neg = (n < 0) != (d < 0);
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = un / ud;
      r = un % ud;
      if ((q >> (32 - FB)) != 0) q = 64'hFFFFFFFF;
      else for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r -= ud;
          q |= 1;
        end
      end
      if (neg) begin
        if (q > 64'h80000000) q = 64'h80000000;
        return 32'(-q);
      end
      if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
      return 32'(q);
    endfunction

    function void note_atom(logic [15:0] w, longint p[3], longint b[3], logic last);
      longint c[10];
      longint d, nx, ny, nz;
      logic [63:0] m, a;
      int s;
      rotor_t r;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          sums[3*i+j] = sat_add(sums[3*i+j], weighted_term(w, p[i], b[j]));
      if (!last) return;
      c[0] = 0;
      c[1] = sat_add(sums[0], sums[4]);
      c[2] = sat_add(sums[4], sums[8]);
      c[3] = sat_add(sums[8], sums[0]);
      c[4] = sat_sub(sums[7], sums[5]);
      c[5] = sat_sub(sums[2], sums[6]);
      c[6] = sat_sub(sums[3], sums[1]);
      c[7] = (sums[1] >>> 1) + (sums[3] >>> 1) + (sums[1] & sums[3] & 1);
      c[8] = (sums[5] >>> 1) + (sums[7] >>> 1) + (sums[5] & sums[7] & 1);
      c[9] = (sums[6] >>> 1) + (sums[2] >>> 1) + (sums[6] & sums[2] & 1);
      m = 0;
      for (int i = 1; i <= 9; i++) begin
        a = c[i] < 0 ? -c[i] : c[i];
        if (a > m) m = a;
      end
      s = 0;
      while ((m >> s) >= (64'd1 << 20)) s++;
      for (int i = 1; i <= 9; i++) begin
        a = (c[i] < 0 ? -c[i] : c[i]) >> s;
        c[i] = c[i] < 0 ? -longint'(a) : longint'(a);
      end
      d = c[1]*c[7]*c[7] + c[2]*c[8]*c[8] + c[3]*c[9]*c[9] + 2*c[7]*c[8]*c[9]
          - c[1]*c[2]*c[3];
      nx = (-c[1]*c[3] + c[8]*c[8])*c[4] - (c[1]*c[7] + c[8]*c[9])*c[5]
           - (c[3]*c[9] + c[7]*c[8])*c[6];
      ny = (-c[2]*c[1] + c[9]*c[9])*c[5] - (c[2]*c[8] + c[9]*c[7])*c[6]
           - (c[1]*c[7] + c[8]*c[9])*c[4];
      nz = (-c[3]*c[2] + c[7]*c[7])*c[6] - (c[3]*c[9] + c[7]*c[8])*c[4]
           - (c[2]*c[8] + c[9]*c[7])*c[5];
      if (d == 0) r = '{0, 0, 0, 1'b1};
      else r = '{rotor_quot(nx, d), rotor_quot(ny, d), rotor_quot(nz, d), 1'b0};
      pending.push_back(r);
      foreach (sums[i]) sums[i] = 0;
    endfunction

    task check_rotor(rotor_t got);
      rotor_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected rotor item", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (got.rx !== e.rx) report_mismatch("rotor_x", got.rx, e.rx);
      if (got.ry !== e.ry) report_mismatch("rotor_y", got.ry, e.ry);
      if (got.rz !== e.rz) report_mismatch("rotor_z", got.rz, e.rz);
      if (got.sing !== e.sing) report_mismatch("singular", got.sing, e.sing);
    endtask
  endclass

  rotor_scoreboard rotor_sb = new();

  // Receiver: stall pattern with quiet stretches.
  always @(negedge clk_i) begin
    if ((cycles / 3000) % 4 == 1) rotor_ch.ready <= 1'b1;
    else rotor_ch.ready <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && rotor_ch.valid && rotor_ch.ready)
      rotor_sb.check_rotor('{rotor_ch.rotor_x, rotor_ch.rotor_y, rotor_ch.rotor_z,
                             rotor_ch.singular});
    if (cycles > 2_000_000) begin
      $display("weighted_rotor_estimator_unit verification failed");
      $finish;
    end
  end

  int burst_left = 0;

  // Sends one atom; handles the sender's burst/gap pattern.
  task automatic send_atom(logic [15:0] w, logic [31:0] p[3], logic [31:0] b[3], logic last);
    longint pl[3], bl[3];
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 80) : 0;
      if (gap > 0) begin
        atom_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    atom_ch.valid     <= 1'b1;
    atom_ch.weight    <= w;
    atom_ch.pos_x     <= p[0];
    atom_ch.pos_y     <= p[1];
    atom_ch.pos_z     <= p[2];
    atom_ch.bond_x    <= b[0];
    atom_ch.bond_y    <= b[1];
    atom_ch.bond_z    <= b[2];
    atom_ch.last_atom <= last;
    do @(posedge clk_i); while (!atom_ch.ready);
    for (int i = 0; i < 3; i++) begin
      pl[i] = longint'($signed(p[i]));
      bl[i] = longint'($signed(b[i]));
    end
    rotor_sb.note_atom(w, pl, bl, last);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2**21)) - 2**20);
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2**25)) - 2**24);
    endcase
  endfunction

  task automatic send_random(logic last);
    logic [31:0] p[3], b[3];
    int mode;
    logic [15:0] w;
    mode = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3;
    for (int i = 0; i < 3; i++) begin
      p[i] = rand_coord(mode);
      b[i] = rand_coord(mode);
    end
    w = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0) : $urandom();
    send_atom(w, p, b, last);
  endtask

  initial begin
    logic [31:0] p[3], b[3];
    int sent, grp;
    atom_ch.valid = 1'b0;
    atom_ch.weight = '0;
    atom_ch.pos_x = '0; atom_ch.pos_y = '0; atom_ch.pos_z = '0;
    atom_ch.bond_x = '0; atom_ch.bond_y = '0; atom_ch.bond_z = '0;
    atom_ch.last_atom = 1'b0;
    rotor_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: all-zero group gives a singular result.
    p = '{0, 0, 0}; b = '{0, 0, 0};
    send_atom(16'h0100, p, b, 1'b1);
    // Zero weight with huge vectors is still singular.
    p = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
    send_atom(16'h0000, p, p, 1'b1);
    // Identity-like rotation.
    p = '{32'h10000, 0, 0}; b = '{0, 32'h10000, 0};
    send_atom(16'h0100, p, b, 1'b0);
    p = '{0, 32'h10000, 0}; b = '{0, 0, 32'h10000};
    send_atom(16'h0100, p, b, 1'b0);
    p = '{0, 0, 32'h10000}; b = '{32'h10000, 0, 0};
    send_atom(16'h0100, p, b, 1'b1);
    // Extreme values give large sums that the solve must normalize, then solve.
    p = '{32'h80000000, 32'h80000000, 32'h7FFFFFFF};
    b = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    repeat (4) send_atom(16'hFFFF, p, b, 1'b0);
    send_atom(16'hFFFF, p, b, 1'b1);
    // Tiny terms that may give large quotients and saturate the rotor.
    p = '{1, 32'hFFFFFFFF, 3}; b = '{5, 7, 32'hFFFFFFFE};
    send_atom(16'h0001, p, b, 1'b1);
    p = '{32'h10000, 32'h20000, 32'h30000}; b = '{32'h10000, 32'hFFFF0000, 32'h8000};
    send_atom(16'h0080, p, b, 1'b1);

    // Random groups, mostly short.
    sent = 0;
    grp = 0;
    while (sent < 1800) begin
      int len;
      len = $urandom_range(0, 5) == 0 ? $urandom_range(6, 20) : $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        send_random(k == len - 1);
        sent++;
      end
      grp++;
      // Hold off until every rotor is out.
      if (grp % 60 == 30) begin
        atom_ch.valid <= 1'b0;
        @(negedge clk_i);
        while (rotor_sb.pending.size() != 0) @(negedge clk_i);
      end
    end
    atom_ch.valid <= 1'b0;
    while (rotor_sb.pending.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (fails == 0) $display("weighted_rotor_estimator_unit verification clean");
    else $display("weighted_rotor_estimator_unit verification failed");
    $finish;
  end
endmodule

[files.f]
design/wre_pkg.sv
design/wre_if.sv
design/wre_div.sv
design/weighted_rotor_estimator_unit.sv
verif/wre_tb_if.sv
verif/testbench.sv
